FILE: sv/rcu_pkg.sv
// Package for the RC channel unpack and scale block: widths, types and constants.
// No dependencies; every other file in sv/ depends on it.
`default_nettype none
package rcu_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] ms_type;
   typedef logic [15:0] hold_type;
   typedef logic [9:0]  raw_type;
   typedef logic [11:0] lvl_type;
   typedef logic [10:0] pulse_type;

   typedef enum logic [1:0] {
      CH_THROTTLE = 2'd0,
      CH_YAW      = 2'd1,
      CH_PITCH    = 2'd2,
      CH_ROLL     = 2'd3
   } ch_type;

   typedef struct packed {
      logic   fire;
      logic   arm_bit;
      ms_type now_ms;
   } dbn_req_type;

   // 1000 offset + 75 trim + 5 for round-to-nearest-ten
   localparam lvl_type   STICK_BASE     = 12'd1080;
   localparam lvl_type   YAW_TRIM       = 12'd5;
   // just above 10 * 2^16 / 9: exact floor(raw*10/9) for raw up to 1023
   localparam logic [16:0] RECIP_9      = 17'd72820;
   // ceil(2^16 / 10): exact floor(v/10) for v up to 2216
   localparam logic [12:0] RECIP_10     = 13'd6554;
   localparam lvl_type   THR_TRIM       = 12'd90;
   localparam lvl_type   ROLL_KNEE      = 12'd1100;
   localparam lvl_type   ROLL_TRIM      = 12'd50;
   localparam lvl_type   PULSE_MAX      = 12'd1900;
   localparam pulse_type ARM_ON_PULSE   = 11'd1600;
   localparam pulse_type ARM_OFF_PULSE  = 11'd900;
   localparam hold_type  ARM_HOLD_RESET = 16'd500;

endpackage
`default_nettype wire

FILE: sv/rcu_if.sv
// Channel interfaces for the RC unpack and scale block: report, pulse and csr beats.
// Depends on rcu_pkg.
`default_nettype none
interface rcu_req_if;
   logic             valid;
   logic             ready;
   rcu_pkg::byte_type yaw_low_byte;
   rcu_pkg::byte_type pitch_low_byte;
   rcu_pkg::byte_type roll_low_byte;
   rcu_pkg::byte_type high_bits_byte;
   rcu_pkg::byte_type throttle_low_byte;
   rcu_pkg::byte_type switch_byte;
   rcu_pkg::ms_type   now_ms;

   modport source (output valid, yaw_low_byte, pitch_low_byte, roll_low_byte,
                   high_bits_byte, throttle_low_byte, switch_byte, now_ms,
                   input ready);
   modport sink   (input valid, yaw_low_byte, pitch_low_byte, roll_low_byte,
                   high_bits_byte, throttle_low_byte, switch_byte, now_ms,
                   output ready);
endinterface

interface rcu_rsp_if;
   logic               valid;
   logic               ready;
   rcu_pkg::pulse_type throttle_pulse;
   rcu_pkg::pulse_type yaw_pulse;
   rcu_pkg::pulse_type pitch_pulse;
   rcu_pkg::pulse_type roll_pulse;
   rcu_pkg::pulse_type arm_pulse;

   modport source (output valid, throttle_pulse, yaw_pulse, pitch_pulse, roll_pulse,
                   arm_pulse, input ready);
   modport sink   (input valid, throttle_pulse, yaw_pulse, pitch_pulse, roll_pulse,
                   arm_pulse, output ready);
endinterface

interface rcu_csr_if;
   logic              valid;
   logic              ready;
   rcu_pkg::hold_type arm_hold_ms;

   modport source (output valid, arm_hold_ms, input ready);
   modport sink   (input valid, arm_hold_ms, output ready);
endinterface
`default_nettype wire

FILE: sv/rcu_lane.sv
// One stick lane: 10/9 scaling in stage 1, round down to a multiple of ten after it.
// Depends on rcu_pkg.
`default_nettype none
module rcu_lane (
   input  logic            clock,
   input  logic            en,
   input  rcu_pkg::ch_type ch,
   input  rcu_pkg::raw_type raw,
   output rcu_pkg::lvl_type level
);
   import rcu_pkg::*;

   logic [26:0] scale_prod;
   lvl_type     trim;
   lvl_type     v1_in;
   lvl_type     v1_ff;
   logic [24:0] round_prod;
   logic [7:0]  tens;

   assign scale_prod = {17'd0, raw} * {10'd0, RECIP_9};

   always_comb begin
      case (ch)
         CH_YAW:  trim = YAW_TRIM;
         default: trim = '0;
      endcase
   end

   assign v1_in = STICK_BASE + {1'b0, scale_prod[26:16]} - trim;

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff <= v1_in;
      end
   end

   assign round_prod = {13'd0, v1_ff} * {12'd0, RECIP_10};
   assign tens       = round_prod[23:16];
   assign level      = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};

endmodule
`default_nettype wire

FILE: sv/rcu_debounce.sv
// Arm switch debounce with the hold-time register; gives the arm state after each beat.
// Depends on rcu_pkg.
`default_nettype none
module rcu_debounce (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  rcu_pkg::hold_type    csr_data,
   input  rcu_pkg::dbn_req_type dbn,
   output logic                 arm_on
);
   import rcu_pkg::*;

   hold_type hold_ff;
   logic     prev_ff, prev_in;
   ms_type   since_ff, since_in;
   logic     arm_ff, arm_in;
   ms_type   elapsed;

   assign elapsed = dbn.now_ms - since_ff;

   always_comb begin
      prev_in  = prev_ff;
      since_in = since_ff;
      arm_in   = arm_ff;
      if (dbn.fire) begin
         prev_in = dbn.arm_bit;
         if (dbn.arm_bit == prev_ff) begin
            if (since_ff == '0) begin
               since_in = dbn.now_ms;
            end else if (elapsed >= {16'd0, hold_ff}) begin
               arm_in = dbn.arm_bit;
            end
         end else begin
            since_in = '0;
            arm_in   = 1'b0;
         end
      end
   end

   assign arm_on = arm_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= ARM_HOLD_RESET;
         prev_ff  <= 1'b0;
         since_ff <= '0;
         arm_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            hold_ff <= csr_data;
         end
         prev_ff  <= prev_in;
         since_ff <= since_in;
         arm_ff   <= arm_in;
      end
   end

   // arm can only be on while the last seen bit is one
   a_arm_needs_bit: assert property (@(posedge clock) disable iff (reset)
      arm_ff |-> prev_ff)
      else $error("arm on with switch bit low");

endmodule
`default_nettype wire

FILE: sv/rc_channel_unpack_and_scale_top.sv
// Top level of the RC channel unpack and scale block: four stick lanes, debounce, merge.
// Depends on rcu_pkg, rcu_if, rcu_lane and rcu_debounce.
//
// Each report beat on req_beat yields one pulse beat on rsp_beat via the two-stage pipe (lane
// scaling register, then the merge/output register); one report is taken every cycle while
// rsp_beat does not stall, and a report is still taken while a finished pulse beat waits if
// stage 1 is empty. Sticks map to 1000 + floor(raw*10/9) + 75, yaw less 5, rounded to the
// nearest ten, throttle less 90, roll less 50 above 1100, capped at 1900. The arm pulse is
// 1600 once the switch bit has held one for arm_hold_ms (reset 500) since the first nonzero
// stamp, else 900. csr_beat is always ready and takes the hold time; write it only while idle.
`default_nettype none
module rc_channel_unpack_and_scale_top (
   input  logic     clock,
   input  logic     reset,
   rcu_req_if.sink   req_beat,
   rcu_rsp_if.source rsp_beat,
   rcu_csr_if.sink   csr_beat
);
   import rcu_pkg::*;

   logic        s1_v_ff, s1_v_in;
   logic        out_v_ff, out_v_in;
   logic        out_take;
   logic        req_fire;
   logic        arm_on;
   logic        arm_s1_ff;
   dbn_req_type dbn;
   raw_type     raw_lane [4];
   lvl_type     lvl_lane [4];
   lvl_type     thr_adj, roll_adj;
   pulse_type   thr_in, yaw_in, pit_in, roll_in, arm_in;
   pulse_type   thr_ff, yaw_ff, pit_ff, roll_ff, arm_ff;

   function automatic pulse_type clamp_pulse(lvl_type v);
      clamp_pulse = (v > PULSE_MAX) ? PULSE_MAX[10:0] : v[10:0];
   endfunction

   assign out_take       = !out_v_ff || rsp_beat.ready;
   assign req_beat.ready = !s1_v_ff || out_take;
   assign req_fire       = req_beat.valid && req_beat.ready;
   assign csr_beat.ready = 1'b1;

   assign raw_lane[CH_THROTTLE] = {req_beat.high_bits_byte[5:4], req_beat.throttle_low_byte};
   assign raw_lane[CH_YAW]      = {req_beat.high_bits_byte[7:6], req_beat.yaw_low_byte};
   assign raw_lane[CH_PITCH]    = {req_beat.high_bits_byte[3:2], req_beat.pitch_low_byte};
   assign raw_lane[CH_ROLL]     = {req_beat.high_bits_byte[1:0], req_beat.roll_low_byte};

   for (genvar g = 0; g < 4; g++) begin : g_lane
      rcu_lane u_lane (
         .clock (clock),
         .en    (req_fire),
         .ch    (ch_type'(g)),
         .raw   (raw_lane[g]),
         .level (lvl_lane[g])
      );
   end

   assign dbn.fire    = req_fire;
   assign dbn.arm_bit = req_beat.switch_byte[0];
   assign dbn.now_ms  = req_beat.now_ms;

   rcu_debounce u_debounce (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_beat.valid && csr_beat.ready),
      .csr_data (csr_beat.arm_hold_ms),
      .dbn      (dbn),
      .arm_on   (arm_on)
   );

   // merge: per-channel trims and cap
   assign thr_adj  = lvl_lane[CH_THROTTLE] - THR_TRIM;
   assign roll_adj = (lvl_lane[CH_ROLL] > ROLL_KNEE) ? (lvl_lane[CH_ROLL] - ROLL_TRIM)
                                                     : lvl_lane[CH_ROLL];
   assign thr_in   = clamp_pulse(thr_adj);
   assign yaw_in   = clamp_pulse(lvl_lane[CH_YAW]);
   assign pit_in   = clamp_pulse(lvl_lane[CH_PITCH]);
   assign roll_in  = clamp_pulse(roll_adj);
   assign arm_in   = arm_s1_ff ? ARM_ON_PULSE : ARM_OFF_PULSE;

   assign s1_v_in  = req_fire ? 1'b1 : (out_take ? 1'b0 : s1_v_ff);
   assign out_v_in = out_take ? s1_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         arm_s1_ff <= arm_on;
      end
      if (out_take && s1_v_ff) begin
         thr_ff  <= thr_in;
         yaw_ff  <= yaw_in;
         pit_ff  <= pit_in;
         roll_ff <= roll_in;
         arm_ff  <= arm_in;
      end
   end

   assign rsp_beat.valid          = out_v_ff;
   assign rsp_beat.throttle_pulse = thr_ff;
   assign rsp_beat.yaw_pulse      = yaw_ff;
   assign rsp_beat.pitch_pulse    = pit_ff;
   assign rsp_beat.roll_pulse     = roll_ff;
   assign rsp_beat.arm_pulse      = arm_ff;

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !out_take) |=> s1_v_ff)
      else $error("stage 1 beat dropped while output stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_v_ff |-> req_beat.ready)
      else $error("not ready with empty stage 1");

   a_arm_code: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (arm_ff == ARM_ON_PULSE || arm_ff == ARM_OFF_PULSE))
      else $error("bad arm pulse");

   // roll just above the knee drops to 1060
   a_stick_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (thr_ff >= 11'd990 && thr_ff <= 11'd1900
                    && yaw_ff >= 11'd1070 && roll_ff >= 11'd1060 && pit_ff >= 11'd1080))
      else $error("stick pulse out of range");

endmodule
`default_nettype wire
